>>> rtl/core/hsase_pkg.sv
// ----------------------------------------------------------------------------
// hsase_pkg
// Types and constants shared by the hall angle/speed estimator modules.
// ----------------------------------------------------------------------------
package hsase_pkg;

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_STALL = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_PNUM   = 2'd2;
  localparam logic [1:0] REG_SNUM   = 2'd3;

  localparam logic [14:0] GAIN_DEFAULT    = 15'd33;
  localparam logic [6:0]  STARTUP_CAPTURE = 7'd30;
  localparam logic [6:0]  STARTUP_LIMIT   = 7'd78;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] timer_count;
    logic [2:0]  hall_code;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] theta;
    logic [15:0]        speed;
    logic [15:0]        phase_step;
    logic [2:0]         sector_now;
    logic               min_speed_ok;
    logic               timer_restart;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // run the part of the op that needs no divider
    logic div_start; // start both quotients
    logic tick_end;  // advance the angle
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } sts_t;

  // sector angle in Q15
  function automatic logic [15:0] sector_angle(input logic [2:0] code);
    case (code)
      3'd1:    sector_angle = 16'd21845;
      3'd2:    sector_angle = 16'hAA98; // -21864
      3'd3:    sector_angle = 16'h8000;
      3'd5:    sector_angle = 16'd10922;
      3'd6:    sector_angle = 16'hD554; // -10924
      default: sector_angle = 16'd0;
    endcase
  endfunction

  // forward order 3,2,6,4,5,1
  function automatic logic [2:0] sector_next(input logic [2:0] code);
    case (code)
      3'd1:    sector_next = 3'd3;
      3'd2:    sector_next = 3'd6;
      3'd3:    sector_next = 3'd2;
      3'd4:    sector_next = 3'd5;
      3'd5:    sector_next = 3'd1;
      3'd6:    sector_next = 3'd4;
      default: sector_next = 3'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/hsase_ctrl.sv
// ----------------------------------------------------------------------------
// hsase_ctrl
// Sequencer: takes an item, runs the divider for ticks, holds the result beat.
// ----------------------------------------------------------------------------
module hsase_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  input  logic              out_stall,
  input  hsase_pkg::sts_t   sts,
  output logic              in_stall,
  output logic              out_valid,
  output hsase_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       take;

  // accept only when idle and the output slot is free or draining
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          if (in_op == hsase_pkg::OP_TICK) begin
            state_next = ST_DIV;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_FIN;
      end
      ST_FIN: begin
        if (sts.div_done) begin
          cmd.tick_end   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/core/hsase_div.sv
// ----------------------------------------------------------------------------
// hsase_div
// Radix-2 restoring divider, two 32/16 quotients in parallel, saturating.
// ----------------------------------------------------------------------------
module hsase_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num_a,
  input  logic [31:0] num_b,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quo_a,
  output logic [15:0] quo_b
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] qa;
  logic [31:0] qb;
  logic [16:0] ra;
  logic [16:0] rb;
  logic [15:0] dv;
  logic [16:0] ra_sh;
  logic [16:0] rb_sh;
  logic        ga;
  logic        gb;

  // one quotient bit per cycle
  assign ra_sh = {ra[15:0], qa[31]};
  assign rb_sh = {rb[15:0], qb[31]};
  assign ga    = ra_sh >= {1'b0, dv};
  assign gb    = rb_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= 5'd0;
      qa  <= num_a;
      qb  <= num_b;
      ra  <= '0;
      rb  <= '0;
      dv  <= den;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      ra  <= ga ? ra_sh - {1'b0, dv} : ra_sh;
      rb  <= gb ? rb_sh - {1'b0, dv} : rb_sh;
      qa  <= {qa[30:0], ga};
      qb  <= {qb[30:0], gb};
    end
  end

  // zero divisor gives all ones, which the saturation also covers
  assign quo_a = (dv == 16'd0 || qa[31:16] != 16'd0) ? 16'hFFFF : qa[15:0];
  assign quo_b = (dv == 16'd0 || qb[31:16] != 16'd0) ? 16'hFFFF : qb[15:0];

endmodule

>>> rtl/core/hsase_dp.sv
// ----------------------------------------------------------------------------
// hsase_dp
// Estimator state, register file, edge logic, period filter, angle update.
// ----------------------------------------------------------------------------
module hsase_dp #(
  parameter int CORRECTION_SHIFT = 3,
  parameter int CORRECTION_STEPS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [31:0]          cfg_data,
  input  hsase_pkg::in_item_t  item,
  input  hsase_pkg::cmd_t      cmd,
  output hsase_pkg::sts_t      sts,
  output hsase_pkg::out_item_t res
);

  logic [14:0] flt_gain;
  logic [15:0] angle_offset;
  logic [31:0] phase_numerator;
  logic [31:0] speed_numerator;
  logic [2:0]  sector;
  logic [15:0] period;
  logic [31:0] filter_accumulator;
  logic [15:0] filtered_period;
  logic [6:0]  startup_count;
  logic        min_speed_flag;
  logic [15:0] angle;
  logic [15:0] correction_step;
  logic [3:0]  correction_left;
  logic [15:0] speed_value;
  logic [15:0] phase_increment;
  logic        restart;

  logic [15:0] per_eff;
  logic [16:0] hi;
  logic        edge_ok;
  logic [15:0] err;
  logic signed [16:0] diff;
  logic signed [32:0] prod;
  logic [31:0] acc_next;
  logic [15:0] ang_a;
  logic [15:0] quo_p;
  logic [15:0] quo_s;
  logic        done;

  // hall edge window
  assign per_eff = (startup_count == hsase_pkg::STARTUP_CAPTURE) ? item.timer_count : period;
  assign hi      = {1'b0, per_eff} + {2'b0, per_eff[15:1]};
  assign edge_ok = item.hall_code == hsase_pkg::sector_next(sector);
  assign err     = hsase_pkg::sector_angle(item.hall_code) + angle_offset - angle;

  // first-order filter
  assign diff     = $signed({1'b0, period}) - $signed({1'b0, filtered_period});
  assign prod     = diff * $signed({1'b0, flt_gain});
  assign acc_next = filter_accumulator + prod[31:0];
  assign ang_a    = angle + quo_p;

  hsase_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num_a (phase_numerator),
    .num_b (speed_numerator),
    .den   (filtered_period),
    .done  (done),
    .quo_a (quo_p),
    .quo_b (quo_s)
  );
  assign sts.div_done = done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flt_gain        <= hsase_pkg::GAIN_DEFAULT;
      angle_offset    <= '0;
      phase_numerator <= '0;
      speed_numerator <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        hsase_pkg::REG_GAIN:   flt_gain        <= cfg_data[14:0];
        hsase_pkg::REG_OFFSET: angle_offset    <= cfg_data[15:0];
        hsase_pkg::REG_PNUM:   phase_numerator <= cfg_data;
        hsase_pkg::REG_SNUM:   speed_numerator <= cfg_data;
        default: ;
      endcase
    end else if (cmd.load && item.op == hsase_pkg::OP_INIT) begin
      flt_gain <= hsase_pkg::GAIN_DEFAULT;
    end
  end

  // estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      sector             <= '0;
      period             <= 16'hFFFF;
      filter_accumulator <= 32'hFFFFFFFF;
      filtered_period    <= 16'hFFFF;
      startup_count      <= '0;
      min_speed_flag     <= 1'b0;
      angle              <= '0;
      correction_step    <= '0;
      correction_left    <= '0;
      speed_value        <= '0;
      phase_increment    <= '0;
      restart            <= 1'b0;
    end else if (cmd.load) begin
      restart <= 1'b0;
      case (item.op)
        hsase_pkg::OP_EDGE: begin
          period <= per_eff;
          if (edge_ok) begin
            restart <= 1'b1;
            sector  <= item.hall_code;
            if (item.timer_count > {1'b0, per_eff[15:1]} && {1'b0, item.timer_count} < hi) begin
              period <= item.timer_count;
            end
            if (startup_count < hsase_pkg::STARTUP_LIMIT) begin
              startup_count <= startup_count + 7'd1;
            end else begin
              min_speed_flag <= 1'b1;
            end
            correction_step <= 16'($signed(err) >>> CORRECTION_SHIFT);
            correction_left <= 4'(CORRECTION_STEPS);
          end
        end
        hsase_pkg::OP_TICK: begin
          filter_accumulator <= acc_next;
          filtered_period    <= acc_next[30:15];
        end
        default: begin
          if (item.op == hsase_pkg::OP_INIT) begin
            sector <= item.hall_code;
          end
          startup_count      <= '0;
          min_speed_flag     <= 1'b0;
          speed_value        <= '0;
          period             <= 16'hFFFF;
          filter_accumulator <= 32'hFFFFFFFF;
          filtered_period    <= 16'hFFFF;
          phase_increment    <= '0;
        end
      endcase
    end else if (cmd.tick_end) begin
      phase_increment <= quo_p;
      speed_value     <= quo_s;
      if (correction_left != 4'd0) begin
        angle           <= ang_a + correction_step;
        correction_left <= correction_left - 4'd1;
      end else begin
        angle <= ang_a;
      end
    end
  end

  assign res.theta         = angle;
  assign res.speed         = speed_value;
  assign res.phase_step    = phase_increment;
  assign res.sector_now    = sector;
  assign res.min_speed_ok  = min_speed_flag;
  assign res.timer_restart = restart;

endmodule

>>> rtl/core/hall_sensor_angle_speed_estimator_top.sv
// ----------------------------------------------------------------------------
// hall_sensor_angle_speed_estimator_top
// Hall edge tracking, period filtering and rotor angle/speed estimation.
// ----------------------------------------------------------------------------
// Each input beat gives one result beat. Hall edge, stall reset and init are
// applied on accept and their result beat is registered; an estimate tick also
// waits on the shared 32-bit restoring divider that forms one quotient bit per
// cycle. One item is in flight at a time; the next is taken once the previous
// result has been handed off. Configuration writes are always taken and belong
// between items, when nothing is in flight.
module hall_sensor_angle_speed_estimator_top #(
  parameter int CORRECTION_SHIFT = 3,
  parameter int CORRECTION_STEPS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hsase_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hsase_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  hsase_pkg::cmd_t cmd;
  hsase_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  hsase_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hsase_dp #(
    .CORRECTION_SHIFT (CORRECTION_SHIFT),
    .CORRECTION_STEPS (CORRECTION_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .item     (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .res      (out_data)
  );

endmodule

>>> rtl/core/hsase_checker.sv
// ----------------------------------------------------------------------------
// hsase_checker
// Port-level checks on the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module hsase_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input hsase_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input hsase_pkg::out_item_t out_data
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no new item while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("item taken while result stalled");

  // a non-tick item shows its result right after the accepting edge
  a_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op != hsase_pkg::OP_TICK |=> ##0 out_valid)
    else $error("result missing after edge or reset op");

  // restart only for a hall edge result
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op != hsase_pkg::OP_EDGE |=> !out_data.timer_restart)
    else $error("timer restart on a non-edge op");

endmodule

bind hall_sensor_angle_speed_estimator_top hsase_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hall angle/speed estimator: directed edge,
// tick, stall and init beats, register sweeps and random rotation sequences,
// with every result beat compared against an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int CORR_SHIFT = 3;
  localparam int CORR_STEPS = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  hsase_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  hsase_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  hall_sensor_angle_speed_estimator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted estimator state
  logic [14:0] p_gain;
  logic [15:0] p_offset;
  logic [31:0] p_pnum, p_snum;
  logic [2:0]  p_sector;
  logic [15:0] p_period, p_fperiod, p_angle, p_cstep, p_speed, p_phase;
  logic [31:0] p_acc;
  logic [6:0]  p_startup;
  logic        p_minflag;
  logic [3:0]  p_cleft;

  hsase_pkg::out_item_t expected_q[$];
  int        errors = 0;
  bit        idle_en = 1'b1;
  bit        hold_rx = 1'b0;

  function automatic logic [15:0] angle_of(logic [2:0] c);
    case (c)
      3'd1:    return 16'd21845;
      3'd2:    return 16'hAA98;
      3'd3:    return 16'h8000;
      3'd5:    return 16'd10922;
      3'd6:    return 16'hD554;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [2:0] next_of(logic [2:0] c);
    case (c)
      3'd1:    return 3'd3;
      3'd2:    return 3'd6;
      3'd3:    return 3'd2;
      3'd4:    return 3'd5;
      3'd5:    return 3'd1;
      3'd6:    return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [15:0] quot_sat(logic [31:0] n, logic [15:0] d);
    logic [31:0] q;
    if (d == 0) return 16'hFFFF;
    q = n / d;
    return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic clear_speed();
    p_startup = '0; p_minflag = 1'b0; p_speed = '0; p_phase = '0;
    p_period = 16'hFFFF; p_fperiod = 16'hFFFF; p_acc = 32'hFFFFFFFF;
  endtask

  task automatic predict_reset();
    p_gain = hsase_pkg::GAIN_DEFAULT; p_offset = '0; p_pnum = '0; p_snum = '0;
    p_sector = '0; p_angle = '0; p_cstep = '0; p_cleft = '0;
    clear_speed();
  endtask

  // next estimator outputs for one accepted input beat
  task automatic predict_beat(hsase_pkg::in_item_t it);
    hsase_pkg::out_item_t r;
    logic [16:0] lo, hi;
    logic [15:0] e;
    logic signed [31:0] diff, prod;
    r = '0;
    case (it.op)
      hsase_pkg::OP_EDGE: begin
        if (p_startup == hsase_pkg::STARTUP_CAPTURE) p_period = it.timer_count;
        lo = {1'b0, p_period} >> 1;
        hi = {1'b0, p_period} + lo;
        if (it.hall_code == next_of(p_sector)) begin
          r.timer_restart = 1'b1;
          p_sector = it.hall_code;
          if ({1'b0, it.timer_count} > lo && {1'b0, it.timer_count} < hi)
            p_period = it.timer_count;
          if (p_startup < hsase_pkg::STARTUP_LIMIT) p_startup++;
          else p_minflag = 1'b1;
          e = angle_of(p_sector) + p_offset - p_angle;
          p_cstep = $unsigned($signed(e) >>> CORR_SHIFT);
          p_cleft = 4'(CORR_STEPS);
        end
      end
      hsase_pkg::OP_TICK: begin
        diff = $signed({16'd0, p_period}) - $signed({16'd0, p_fperiod});
        prod = diff * $signed({17'd0, p_gain});
        p_acc = p_acc + prod;
        p_fperiod = p_acc[30:15];
        p_phase = quot_sat(p_pnum, p_fperiod);
        p_speed = quot_sat(p_snum, p_fperiod);
        p_angle = p_angle + p_phase;
        if (p_cleft != 0) begin
          p_angle = p_angle + p_cstep;
          p_cleft--;
        end
      end
      hsase_pkg::OP_STALL: clear_speed();
      default: begin
        p_gain = hsase_pkg::GAIN_DEFAULT;
        p_sector = it.hall_code;
        clear_speed();
      end
    endcase
    r.theta = p_angle; r.speed = p_speed; r.phase_step = p_phase;
    r.sector_now = p_sector; r.min_speed_ok = p_minflag;
    expected_q.push_back(r);
  endtask

  // send one input beat, with an optional random gap first
  task automatic send_item(logic [1:0] op, logic [15:0] tc, logic [2:0] hc);
    hsase_pkg::in_item_t it;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    it.op = op; it.timer_count = tc; it.hall_code = hc;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(it);
    @(negedge clk);
  endtask

  // stop offering beats and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hsase_pkg::REG_GAIN:   p_gain = val[14:0];
      hsase_pkg::REG_OFFSET: p_offset = val[15:0];
      hsase_pkg::REG_PNUM:   p_pnum = val;
      hsase_pkg::REG_SNUM:   p_snum = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [14:0] g, logic [15:0] o, logic [31:0] pn,
                          logic [31:0] sn);
    drain();
    write_reg(hsase_pkg::REG_GAIN, {17'd0, g});
    write_reg(hsase_pkg::REG_OFFSET, {16'd0, o});
    write_reg(hsase_pkg::REG_PNUM, pn);
    write_reg(hsase_pkg::REG_SNUM, sn);
    cfg_valid <= 1'b0;
  endtask

  // one well-formed rotation edge with a period near the nominal one
  task automatic good_edge(logic [15:0] nominal);
    int j;
    j = $urandom_range(0, nominal / 8);
    send_item(hsase_pkg::OP_EDGE, nominal - nominal / 16 + j[15:0], next_of(p_sector));
  endtask

  // receiver side: random stalls plus long hold-off when asked
  always @(negedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if (idle_en && $urandom_range(0, 4) == 0) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    hsase_pkg::out_item_t x;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        x = expected_q.pop_front();
        if (out_data.theta !== x.theta) begin
          $display("%0t: theta exp %h got %h", $time, x.theta, out_data.theta);
          errors++;
        end
        if (out_data.speed !== x.speed) begin
          $display("%0t: speed exp %h got %h", $time, x.speed, out_data.speed);
          errors++;
        end
        if (out_data.phase_step !== x.phase_step) begin
          $display("%0t: phase_step exp %h got %h", $time, x.phase_step,
                   out_data.phase_step);
          errors++;
        end
        if (out_data.sector_now !== x.sector_now) begin
          $display("%0t: sector exp %h got %h", $time, x.sector_now,
                   out_data.sector_now);
          errors++;
        end
        if (out_data.min_speed_ok !== x.min_speed_ok) begin
          $display("%0t: min_speed exp %b got %b", $time, x.min_speed_ok,
                   out_data.min_speed_ok);
          errors++;
        end
        if (out_data.timer_restart !== x.timer_restart) begin
          $display("%0t: restart exp %b got %b", $time, x.timer_restart,
                   out_data.timer_restart);
          errors++;
        end
      end
    end
  end

  // directed: every op, field extremes, invalid sectors, saturation
  task automatic test_directed();
    send_item(hsase_pkg::OP_TICK, 16'h0000, 3'd0);
    send_item(hsase_pkg::OP_EDGE, 16'hFFFF, 3'd0);
    send_item(hsase_pkg::OP_EDGE, 16'h0000, 3'd7);
    send_item(hsase_pkg::OP_INIT, 16'hFFFF, 3'd7);
    send_item(hsase_pkg::OP_EDGE, 16'h1234, 3'd0);
    send_item(hsase_pkg::OP_INIT, 16'h0000, 3'd3);
    send_item(hsase_pkg::OP_EDGE, 16'h8000, 3'd2);
    send_item(hsase_pkg::OP_EDGE, 16'h8000, 3'd5);
    send_item(hsase_pkg::OP_EDGE, 16'h5000, 3'd6);
    send_item(hsase_pkg::OP_EDGE, 16'hBFFF, 3'd4);
    send_item(hsase_pkg::OP_EDGE, 16'h0001, 3'd5);
    send_item(hsase_pkg::OP_EDGE, 16'hFFFE, 3'd1);
    send_item(hsase_pkg::OP_TICK, 16'hFFFF, 3'd7);
    send_item(hsase_pkg::OP_STALL, 16'hFFFF, 3'd7);
    send_item(hsase_pkg::OP_TICK, 16'h0, 3'd0);
    set_regs(15'h7FFF, 16'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF);
    repeat (4) send_item(hsase_pkg::OP_TICK, 16'h0, 3'd0);
    send_item(hsase_pkg::OP_EDGE, 16'h0100, 3'd3);
    repeat (3) send_item(hsase_pkg::OP_TICK, 16'h0, 3'd0);
  endtask

  // startup: run past the capture and limit counts, then stall reset
  task automatic test_startup();
    set_regs(15'd2000, 16'h0100, 32'h0010_0000, 32'h0008_0000);
    send_item(hsase_pkg::OP_INIT, 16'h0, 3'd1);
    for (int i = 0; i < 90; i++) begin
      good_edge(16'd3000);
      if (i % 3 == 0) send_item(hsase_pkg::OP_TICK, 16'h0, 3'd0);
    end
    send_item(hsase_pkg::OP_STALL, 16'h0, 3'd0);
    for (int i = 0; i < 10; i++) good_edge(16'd3000);
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    drain();
    fork
      begin
        hold_rx = 1'b1;
        repeat (200) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 12; i++) good_edge(16'd1000);
    join
    drain();
  endtask

  // random: mostly forward rotation, some ticks, noise and resets
  task automatic test_random(int n, logic [15:0] nominal);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) good_edge(nominal);
      else if (k < 80) send_item(hsase_pkg::OP_TICK, 16'($urandom), 3'($urandom));
      else if (k < 92) send_item(hsase_pkg::OP_EDGE, 16'($urandom), 3'($urandom));
      else if (k < 96) send_item(hsase_pkg::OP_STALL, 16'($urandom), 3'($urandom));
      else send_item(hsase_pkg::OP_INIT, 16'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    predict_reset();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_startup();
    test_backpressure();
    set_regs(15'd0, 16'h7FFF, 32'd0, 32'd0);
    test_random(150, 16'd500);
    set_regs(15'($urandom), 16'($urandom), $urandom, $urandom);
    test_random(300, 16'($urandom_range(100, 60000)));
    set_regs(15'd33, 16'h0, 32'h0200_0000, 32'h0000_0001);
    test_random(300, 16'd20000);
    idle_en = 1'b0;
    set_regs(15'($urandom), 16'($urandom), $urandom, $urandom);
    test_random(250, 16'd4000);
    drain();
    if (errors == 0 && expected_q.size() == 0)
      $display("** hall_sensor_angle_speed_estimator_top: PASSED **");
    else
      $display("** hall_sensor_angle_speed_estimator_top: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** hall_sensor_angle_speed_estimator_top: FAILED **");
    $finish;
  end

endmodule
